// ===== hdl/patt_pkg.sv =====
// ----------------------------------------------------------------------------
// Periodic alarm table package
// Shared widths, opcodes, register indexes and the controller command type.
// ----------------------------------------------------------------------------
`default_nettype none

package patt_pkg;

   // payload widths
   localparam int OP_W      = 2;
   localparam int CHAN_W    = 2;
   localparam int SEC_W     = 32;
   localparam int UNIT_W    = 2;
   localparam int COUNT_W   = 16;
   localparam int UNITSEC_W = 17;

   // default table size
   localparam int CHANNELS_DEF = 4;

   // one unit and one count register per channel slot
   localparam int NUM_SLOTS   = 4;
   localparam int SLOT_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // register index map
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_BASE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_BASE = 3'd4;

   // opcodes
   localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
   localparam logic [OP_W-1:0] OP_SET_EN = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // period unit codes
   localparam logic [UNIT_W-1:0] UNIT_SEC  = 2'd0;
   localparam logic [UNIT_W-1:0] UNIT_MIN  = 2'd1;
   localparam logic [UNIT_W-1:0] UNIT_HOUR = 2'd2;
   localparam logic [UNIT_W-1:0] UNIT_DAY  = 2'd3;

   localparam logic [UNITSEC_W-1:0] SECS_PER_SEC  = UNITSEC_W'(1);
   localparam logic [UNITSEC_W-1:0] SECS_PER_MIN  = UNITSEC_W'(60);
   localparam logic [UNITSEC_W-1:0] SECS_PER_HOUR = UNITSEC_W'(60 * 60);
   localparam logic [UNITSEC_W-1:0] SECS_PER_DAY  = UNITSEC_W'(60 * 60 * 24);

   // controller to datapath commands
   typedef struct packed {
      logic load;    // latch the accepted request
      logic calc;    // period product and compares
      logic commit;  // table write and result register load
   } patt_cmd_type;

   function automatic logic [UNITSEC_W-1:0] unit_seconds(input logic [UNIT_W-1:0] unit);
      logic [UNITSEC_W-1:0] secs;
      case (unit)
         UNIT_SEC:  secs = SECS_PER_SEC;
         UNIT_MIN:  secs = SECS_PER_MIN;
         UNIT_HOUR: secs = SECS_PER_HOUR;
         UNIT_DAY:  secs = SECS_PER_DAY;
         default:   secs = SECS_PER_DAY;
      endcase
      return secs;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/patt_intf.sv =====
// ----------------------------------------------------------------------------
// Periodic alarm table channel interfaces
// Valid/ready request and response channels with their payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface patt_req_intf;
   logic                          valid;
   logic                          ready;
   logic [patt_pkg::OP_W-1:0]     opcode;
   logic [patt_pkg::CHAN_W-1:0]   channel;
   logic [patt_pkg::SEC_W-1:0]    now_seconds;
   logic                          enable_value;

   modport source (output valid, opcode, channel, now_seconds, enable_value,
                   input ready);
   modport sink   (input valid, opcode, channel, now_seconds, enable_value,
                   output ready);
endinterface

interface patt_rsp_intf;
   logic valid;
   logic ready;
   logic chan_enabled;
   logic chan_triggered;

   modport source (output valid, chan_enabled, chan_triggered, input ready);
   modport sink   (input valid, chan_enabled, chan_triggered, output ready);
endinterface

`default_nettype wire

// ===== hdl/periodic_action_trigger_table.sv =====
// ----------------------------------------------------------------------------
// Periodic action trigger table
// Table of periodic alarm channels driven by update/enable/clear transactions.
// ----------------------------------------------------------------------------
// Each request transaction addresses one alarm channel and returns exactly one
// response transaction carrying that channel's enable and triggered flags
// after the operation. Update hands the channel the current epoch second; an
// enabled, untriggered channel seeing a new second records it and, once the
// due second is reached, latches its triggered flag and reschedules itself to
// now + count * unit (wrapping modulo 2^32). Set enable writes the flag and
// zeroes both times; clear drops the triggered flag; opcode 3 changes nothing.
// A channel index at or above CHANNELS leaves the table alone and reports
// zeros. Each transaction passes the request latch, the period multiply
// (16 x 17 bit) with the due compare, then the table commit into the response
// register. The commit waits while an earlier response is still held, and the
// next request is only taken once the previous one has been committed.
// A new request is taken while the previous response waits to be collected.
// Config registers (units at index 0..3, counts at 4..7) are written through
// the csr_ port and must only change while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_action_trigger_table #(
   parameter int CHANNELS = patt_pkg::CHANNELS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   patt_req_intf.sink                             req_chan,
   patt_rsp_intf.source                           rsp_chan,
   input  wire logic                              csr_wr_en,
   input  wire logic [patt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [patt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import patt_pkg::*;

   patt_cmd_type cmd;

   // sequencer: accept, calc, commit
   patt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // channel table, config and result register
   patt_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .opcode         (req_chan.opcode),
      .channel        (req_chan.channel),
      .now_seconds    (req_chan.now_seconds),
      .enable_value   (req_chan.enable_value),
      .chan_enabled   (rsp_chan.chan_enabled),
      .chan_triggered (rsp_chan.chan_triggered)
   );

endmodule

`default_nettype wire

// ===== hdl/patt_ctrl.sv =====
// ----------------------------------------------------------------------------
// Periodic alarm table controller
// Sequences load, calc and commit; owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module patt_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      patt_pkg::patt_cmd_type cmd
);
   import patt_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_CALC   = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   // result register free now or emptied at this edge
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.load   = (state_ff == ST_IDLE) && req_valid;
      cmd.calc   = (state_ff == ST_CALC);
      cmd.commit = (state_ff == ST_COMMIT) && slot_free;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_CALC;
         ST_CALC:   state_in = ST_COMMIT;
         ST_COMMIT: if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/patt_dp.sv =====
// ----------------------------------------------------------------------------
// Periodic alarm table datapath
// Config registers, channel table, period product and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module patt_dp #(
   parameter int CHANNELS = patt_pkg::CHANNELS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire patt_pkg::patt_cmd_type            cmd,
   input  wire logic                              csr_wr_en,
   input  wire logic [patt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [patt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [patt_pkg::OP_W-1:0]         opcode,
   input  wire logic [patt_pkg::CHAN_W-1:0]       channel,
   input  wire logic [patt_pkg::SEC_W-1:0]        now_seconds,
   input  wire logic                              enable_value,
   output      logic                              chan_enabled,
   output      logic                              chan_triggered
);
   import patt_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // config registers
   logic [UNIT_W-1:0]  unit_ff  [NUM_SLOTS];
   logic [COUNT_W-1:0] count_ff [NUM_SLOTS];

   // channel table
   logic             en_ff   [CHANNELS];
   logic             en_in   [CHANNELS];
   logic             trig_ff [CHANNELS];
   logic             trig_in [CHANNELS];
   logic [SEC_W-1:0] last_ff [CHANNELS];
   logic [SEC_W-1:0] last_in [CHANNELS];
   logic [SEC_W-1:0] due_ff  [CHANNELS];
   logic [SEC_W-1:0] due_in  [CHANNELS];

   // latched request
   logic [OP_W-1:0]   op_ff;
   logic [CHAN_W-1:0] chan_ff;
   logic [SEC_W-1:0]  now_ff;
   logic              env_ff;
   logic              in_range_ff;
   logic [IDX_W-1:0]  idx;

   // calc stage
   logic [SEC_W-1:0]  period_ff;
   logic              upd_ff;
   logic              due_hit_ff;
   logic [SEC_W-1:0]  product;

   // result register
   logic out_en_ff, out_en_in;
   logic out_trig_ff, out_trig_in;

   assign idx = IDX_W'(chan_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            unit_ff[i]  <= UNIT_W'(i);
            count_ff[i] <= COUNT_W'(1);
         end
      end else if (csr_wr_en) begin
         if (csr_index < CSR_COUNT_BASE) begin
            unit_ff[SLOT_W'(csr_index - CSR_UNIT_BASE)] <= csr_wdata[UNIT_W-1:0];
         end else begin
            count_ff[SLOT_W'(csr_index - CSR_COUNT_BASE)] <= csr_wdata[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= opcode;
         chan_ff     <= channel;
         now_ff      <= now_seconds;
         env_ff      <= enable_value;
         in_range_ff <= (32'(channel) < CHANNELS);
      end
   end

   // product bits above 32 wrap away
   assign product = SEC_W'(count_ff[chan_ff]) * SEC_W'(unit_seconds(unit_ff[chan_ff]));

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         period_ff  <= product;
         upd_ff     <= en_ff[idx] && !trig_ff[idx] && (last_ff[idx] != now_ff);
         due_hit_ff <= (now_ff >= due_ff[idx]);
      end
   end

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         en_in[i]   = en_ff[i];
         trig_in[i] = trig_ff[i];
         last_in[i] = last_ff[i];
         due_in[i]  = due_ff[i];
      end
      out_en_in   = out_en_ff;
      out_trig_in = out_trig_ff;
      if (cmd.commit) begin
         out_en_in   = 1'b0;
         out_trig_in = 1'b0;
         if (in_range_ff) begin
            case (op_ff)
               OP_UPDATE: begin
                  if (upd_ff) begin
                     last_in[idx] = now_ff;
                     if (due_hit_ff) begin
                        due_in[idx]  = now_ff + period_ff;
                        trig_in[idx] = 1'b1;
                     end
                  end
               end
               OP_SET_EN: begin
                  en_in[idx]   = env_ff;
                  last_in[idx] = '0;
                  due_in[idx]  = '0;
               end
               OP_CLEAR: trig_in[idx] = 1'b0;
               default: ;
            endcase
            out_en_in   = en_in[idx];
            out_trig_in = trig_in[idx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            en_ff[i]   <= 1'b0;
            trig_ff[i] <= 1'b0;
            last_ff[i] <= '0;
            due_ff[i]  <= '0;
         end
      end else begin
         for (int i = 0; i < CHANNELS; i++) begin
            en_ff[i]   <= en_in[i];
            trig_ff[i] <= trig_in[i];
            last_ff[i] <= last_in[i];
            due_ff[i]  <= due_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      out_en_ff   <= out_en_in;
      out_trig_ff <= out_trig_in;
   end

   assign chan_enabled   = out_en_ff;
   assign chan_triggered = out_trig_ff;

endmodule

`default_nettype wire

// ===== tb/periodic_action_trigger_table_test.sv =====
// ----------------------------------------------------------------------------
// Periodic action trigger table testbench
// Drives update, enable, clear and reserved-opcode transactions into the alarm
// table. A local predictor keeps its own copy of the channel table and period
// registers, works out the flags each transaction should return, and checks
// the response stream against them in order. Both sides idle and stall at
// random, and the period registers are reprogrammed between phases.
// ----------------------------------------------------------------------------
module periodic_action_trigger_table_test;
   import patt_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int CLOCK_PERIOD  = 2 * HALF_PERIOD;
   localparam int RESET_CYCLES  = 5;
   localparam int LIMIT_CYCLES  = 1_000_000;   // far above the slowest legal run
   localparam int QUIET_CYCLES  = 8;           // pipe drain plus margin
   localparam int ALARM_CHANNELS = CHANNELS_DEF;
   localparam int PHASES        = 7;
   localparam int PHASE_ITEMS   = 205;
   localparam int MAX_PRINTED   = 30;

   // the one opcode the block leaves unused
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [CHAN_W-1:0] channel;
      logic [SEC_W-1:0]  now_seconds;
      logic              enable_value;
   } alarm_req_type;

   typedef struct packed {
      logic enabled;
      logic triggered;
   } alarm_flags_type;

   // ------------------------------------------------------------------------
   // Clock, reset and channels
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   always #HALF_PERIOD clock = ~clock;

   patt_req_intf req_chan ();
   patt_rsp_intf rsp_chan ();

   periodic_action_trigger_table #(
      .CHANNELS (ALARM_CHANNELS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Predictor state: channel table plus shadow of the period registers
   // ------------------------------------------------------------------------
   logic              alarm_en   [ALARM_CHANNELS];
   logic              alarm_trig [ALARM_CHANNELS];
   logic [SEC_W-1:0]  alarm_last [ALARM_CHANNELS];
   logic [SEC_W-1:0]  alarm_due  [ALARM_CHANNELS];
   logic [UNIT_W-1:0]  period_unit  [NUM_SLOTS];
   logic [COUNT_W-1:0] period_count [NUM_SLOTS];

   alarm_req_type   queued_requests [$];   // waiting to be driven
   alarm_flags_type expected_flags  [$];   // predicted, waiting for the response

   int  cycle_count    = 0;
   int  req_hold_until = 0;
   int  rsp_hold_until = 0;
   int  fault_count    = 0;
   int  result_count   = 0;
   int  items_queued   = 0;
   bit  idle_on        = 1'b1;

   alarm_req_type   taken_req;
   alarm_flags_type want_flags;

   // Apply one transaction to the predicted table and return the flags the
   // block should report for it.
   function automatic alarm_flags_type advance_alarm(input alarm_req_type r);
      alarm_flags_type  flags;
      logic [SEC_W-1:0] span;
      logic [SEC_W-1:0] period;
      flags = '0;
      // out-of-range channel: table untouched, flags read as zero
      if (int'(r.channel) >= ALARM_CHANNELS) return flags;
      case (r.opcode)
         OP_UPDATE: begin
            // only an enabled, untriggered channel seeing a new second moves
            if (alarm_en[r.channel] && !alarm_trig[r.channel] &&
                alarm_last[r.channel] != r.now_seconds) begin
               alarm_last[r.channel] = r.now_seconds;
               if (r.now_seconds >= alarm_due[r.channel]) begin
                  case (period_unit[r.channel])
                     UNIT_SEC:  span = SEC_W'(SECS_PER_SEC);
                     UNIT_MIN:  span = SEC_W'(SECS_PER_MIN);
                     UNIT_HOUR: span = SEC_W'(SECS_PER_HOUR);
                     default:   span = SEC_W'(SECS_PER_DAY);
                  endcase
                  // product and sum both wrap at 32 bits
                  period = SEC_W'(period_count[r.channel]) * span;
                  alarm_due[r.channel]  = r.now_seconds + period;
                  alarm_trig[r.channel] = 1'b1;
               end
            end
         end
         OP_SET_EN: begin
            alarm_en[r.channel]   = r.enable_value;
            alarm_last[r.channel] = '0;
            alarm_due[r.channel]  = '0;
         end
         OP_CLEAR: alarm_trig[r.channel] = 1'b0;
         default: ;   // reserved opcode: no change
      endcase
      flags.enabled   = alarm_en[r.channel];
      flags.triggered = alarm_trig[r.channel];
      return flags;
   endfunction

   task automatic report_fault(input string msg);
      if (fault_count < MAX_PRINTED) $display("%0t: mismatch: %s", $time, msg);
      fault_count++;
   endtask

   // Mostly short gaps, some medium, the odd long one; none while idling is off.
   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: everything sampled at the rising edge. Responses are checked
   // before the request of the same edge is predicted, so a transaction can
   // never be matched against its own expectation too early.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            result_count++;
            if (expected_flags.size() == 0) begin
               report_fault($sformatf("result %0d arrived with nothing expected",
                                      result_count));
            end else begin
               want_flags = expected_flags.pop_front();
               if (rsp_chan.chan_enabled !== want_flags.enabled)
                  report_fault($sformatf("result %0d chan_enabled: expected %0b, got %0b",
                                         result_count, want_flags.enabled,
                                         rsp_chan.chan_enabled));
               if (rsp_chan.chan_triggered !== want_flags.triggered)
                  report_fault($sformatf("result %0d chan_triggered: expected %0b, got %0b",
                                         result_count, want_flags.triggered,
                                         rsp_chan.chan_triggered));
            end
            rsp_hold_until = cycle_count + draw_gap();
         end
         if (req_chan.valid && req_chan.ready) begin
            taken_req = queued_requests.pop_front();
            expected_flags.push_back(advance_alarm(taken_req));
            req_hold_until = cycle_count + draw_gap();
         end
      end
   end

   // ------------------------------------------------------------------------
   // Driver: inputs move at the falling edge. Valid is only dropped after an
   // accepted transaction, so an offered request is always held until taken.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || queued_requests.size() == 0 || cycle_count < req_hold_until) begin
         req_chan.valid <= 1'b0;
      end else begin
         req_chan.valid        <= 1'b1;
         req_chan.opcode       <= queued_requests[0].opcode;
         req_chan.channel      <= queued_requests[0].channel;
         req_chan.now_seconds  <= queued_requests[0].now_seconds;
         req_chan.enable_value <= queued_requests[0].enable_value;
      end
      rsp_chan.ready <= !reset && cycle_count >= rsp_hold_until;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void queue_req(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                                     input logic [SEC_W-1:0] now, input logic en);
      alarm_req_type r;
      r.opcode       = op;
      r.channel      = ch;
      r.now_seconds  = now;
      r.enable_value = en;
      queued_requests.push_back(r);
      items_queued++;
   endfunction

   // Block must be idle: nothing queued, nothing outstanding, pipe drained.
   task automatic wait_quiet();
      while (queued_requests.size() != 0 || expected_flags.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // Write one register; the shadow follows at the same edge.
   task automatic write_csr(input int idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_wdata <= data;
      @(posedge clock);
      if (idx < int'(CSR_COUNT_BASE)) period_unit[idx] = data[UNIT_W-1:0];
      else period_count[idx - int'(CSR_COUNT_BASE)] = data;
   endtask

   task automatic program_slot(input int slot, input logic [CSR_DATA_W-1:0] unit_word,
                               input logic [CSR_DATA_W-1:0] count_word);
      write_csr(int'(CSR_UNIT_BASE) + slot, unit_word);
      write_csr(int'(CSR_COUNT_BASE) + slot, count_word);
   endtask

   // Random count biased to the extremes and to short periods.
   function automatic logic [CSR_DATA_W-1:0] draw_count();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      if (roll < 4) return CSR_DATA_W'($urandom_range(1, 5));
      return CSR_DATA_W'($urandom_range(0, 65535));
   endfunction

   // A burst of mostly well-formed traffic. Update times are steered from a
   // per-channel cursor and from the due second known at burst start, so the
   // due compare is hit from below, on the spot and from above.
   task automatic queue_burst(input int n);
      logic [SEC_W-1:0] cursor   [ALARM_CHANNELS];
      logic [SEC_W-1:0] due_seen [ALARM_CHANNELS];
      logic [SEC_W-1:0] now;
      logic [CHAN_W-1:0] ch;
      int roll;
      for (int c = 0; c < ALARM_CHANNELS; c++) begin
         cursor[c]   = alarm_last[c];
         due_seen[c] = alarm_due[c];
      end
      for (int i = 0; i < n; i++) begin
         ch   = CHAN_W'($urandom_range(0, ALARM_CHANNELS - 1));
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            queue_req(OP_SET_EN, ch, $urandom, $urandom_range(0, 9) != 0);
            cursor[ch]   = '0;
            due_seen[ch] = '0;
         end else if (roll < 26) begin
            queue_req(OP_CLEAR, ch, $urandom, 1'($urandom));
         end else if (roll < 30) begin
            queue_req(OP_NONE, ch, $urandom, 1'($urandom));
         end else begin
            case ($urandom_range(0, 9))
               0:       now = due_seen[ch] - 1;
               1:       now = due_seen[ch];
               2:       now = due_seen[ch] + $urandom_range(1, 3);
               3:       now = cursor[ch];                   // same second again
               7:       now = $urandom;
               8:       now = 32'hFFFF_FFFF - $urandom_range(0, 3);
               9:       now = cursor[ch] + $urandom_range(50, 100000);
               default: now = cursor[ch] + $urandom_range(1, 5);
            endcase
            cursor[ch] = now;
            queue_req(OP_UPDATE, ch, now, 1'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_chan.valid        = 1'b0;
      req_chan.opcode       = OP_UPDATE;
      req_chan.channel      = '0;
      req_chan.now_seconds  = '0;
      req_chan.enable_value = 1'b0;
      rsp_chan.ready        = 1'b0;
      // reset values of table and registers
      for (int c = 0; c < ALARM_CHANNELS; c++) begin
         alarm_en[c]   = 1'b0;
         alarm_trig[c] = 1'b0;
         alarm_last[c] = '0;
         alarm_due[c]  = '0;
      end
      for (int s = 0; s < NUM_SLOTS; s++) begin
         period_unit[s]  = UNIT_W'(s);
         period_count[s] = COUNT_W'(1);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part on reset-value periods (1 s, 1 min, 1 h, 1 day).
      queue_req(OP_UPDATE, 2'd0, 32'd5, 1'b0);          // disabled channel ignores time
      queue_req(OP_NONE,   2'd1, 32'd0, 1'b0);          // reserved opcode
      queue_req(OP_SET_EN, 2'd0, 32'd0, 1'b1);
      queue_req(OP_UPDATE, 2'd0, 32'd0, 1'b0);          // same as last second: no change
      queue_req(OP_UPDATE, 2'd0, 32'hFFFF_FFFF, 1'b0);  // fires, due wraps to zero
      queue_req(OP_UPDATE, 2'd0, 32'd7, 1'b0);          // sticky while triggered
      queue_req(OP_CLEAR,  2'd0, 32'd0, 1'b0);
      queue_req(OP_UPDATE, 2'd0, 32'd7, 1'b0);          // wrapped due lies below now
      queue_req(OP_CLEAR,  2'd0, 32'd0, 1'b0);
      queue_req(OP_UPDATE, 2'd0, 32'd7, 1'b0);          // repeated second
      queue_req(OP_UPDATE, 2'd0, 32'd8, 1'b0);          // exactly on due
      queue_req(OP_SET_EN, 2'd3, 32'd0, 1'b1);
      queue_req(OP_UPDATE, 2'd3, 32'd100, 1'b0);
      queue_req(OP_CLEAR,  2'd3, 32'd0, 1'b0);
      queue_req(OP_UPDATE, 2'd3, 32'd86499, 1'b0);      // one second short of the due second
      queue_req(OP_UPDATE, 2'd3, 32'd86500, 1'b0);
      queue_req(OP_SET_EN, 2'd3, 32'd0, 1'b0);          // disable keeps triggered
      queue_req(OP_UPDATE, 2'd3, 32'd90000, 1'b1);
      queue_req(OP_CLEAR,  2'd3, 32'hFFFF_FFFF, 1'b1);
      queue_req(OP_SET_EN, 2'd1, 32'd0, 1'b1);
      queue_req(OP_UPDATE, 2'd1, 32'h8000_0000, 1'b0);
      queue_req(OP_NONE,   2'd1, 32'h5A5A_A5A5, 1'b1);
      queue_req(OP_CLEAR,  2'd2, 32'd0, 1'b0);
      queue_req(OP_SET_EN, 2'd2, 32'hFFFF_FFFF, 1'b1);

      // Random phases. Each starts with the block drained, so the sender
      // also stalls until every outstanding response has come back.
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_quiet();
         idle_on = (phase % 3) != 2;   // every third phase runs flat out
         case (phase)
            0: begin
               // upper data bits set on unit writes, block keeps the low two
               program_slot(0, 16'h0000, 16'h0000);
               program_slot(1, 16'h0003, 16'hFFFF);   // largest period, wraps
               program_slot(2, 16'hFFFC, 16'hFFFF);
               program_slot(3, 16'hFFFF, 16'h0001);
            end
            1: begin
               program_slot(0, CSR_DATA_W'(UNIT_DAY),  16'hFFFF);
               program_slot(1, CSR_DATA_W'(UNIT_HOUR), 16'h0000);
               program_slot(2, CSR_DATA_W'(UNIT_MIN),  16'h0001);
               program_slot(3, CSR_DATA_W'(UNIT_SEC),  16'hFFFF);
            end
            default: begin
               for (int s = 0; s < NUM_SLOTS; s++)
                  program_slot(s, CSR_DATA_W'($urandom_range(0, 65535)), draw_count());
            end
         endcase
         @(negedge clock);
         csr_wr_en <= 1'b0;

         while (items_queued < 24 + (phase + 1) * PHASE_ITEMS) begin
            while (queued_requests.size() != 0) @(posedge clock);
            queue_burst($urandom_range(3, 24));
         end
      end

      wait_quiet();
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Hung handshake guard
   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
